// ----- hdl/ocd_pkg.sv -----
// ----------------------------------------------------------------------------
// OFDM per-carrier depuncturer package
// Shared widths, codes, types and the mode tables of the depuncturer.
// ----------------------------------------------------------------------------
package ocd_pkg;

    localparam int CARRIERS = 256;
    localparam int IDX_W    = 8;
    localparam int PTR_W    = 9;
    localparam int MODE_W   = 4;
    localparam int VAL_W    = 8;
    localparam int POS_W    = 4;
    localparam int REP_W    = 3;
    localparam int CNT_W    = 2;

    localparam logic [MODE_W-1:0] MODE_MAX = MODE_W'(9);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_DATA  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PUR_START,
        PUR_DATA,
        PUR_AFTER
    } purpose_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [MODE_W-1:0] mode;
    } map_wr_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    is_fill;
        logic                    last;
        logic                    symbol_end;
        logic                    no_carrier;
    } result_t;

    function automatic logic [REP_W:0] rep_of(input logic [MODE_W-1:0] m);
        logic [REP_W:0] r;
        case (m)
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd1;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd2;
            4'd6:    r = 4'd4;
            4'd7:    r = 4'd3;
            4'd8:    r = 4'd2;
            4'd9:    r = 4'd4;
            default: r = 4'd2;
        endcase
        return r;
    endfunction

    function automatic logic [POS_W-1:0] plen_of(input logic [MODE_W-1:0] m);
        logic [POS_W-1:0] l;
        case (m)
            4'd3, 4'd5, 4'd7, 4'd9: l = 4'd6;
            4'd6:                   l = 4'd4;
            4'd8:                   l = 4'd10;
            default:                l = 4'd1;
        endcase
        return l;
    endfunction

    function automatic logic [15:0] pbits_of(input logic [MODE_W-1:0] m);
        logic [15:0] b;
        case (m)
            4'd3, 4'd5, 4'd7, 4'd9: b = 16'h001B;
            4'd6:                   b = 16'h000B;
            4'd8:                   b = 16'h019B;
            default:                b = 16'h0001;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/ofdm_per_carrier_depuncturer_top.sv -----
// ----------------------------------------------------------------------------
// OFDM per-carrier depuncturer, top level
// A start scans the map up to the first used carrier. A data beat skips
// unused carriers, scans on to the next used carrier after a finished one,
// and then emits 1 to 3 result beats; the map is walked serially through
// one read port.
// Reset clears the whole mode map at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module ofdm_per_carrier_depuncturer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // carrier_index[7:0], mode[11:8], in_value[19:12]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_value[7:0]
    output logic [2:0]  m_axis_tuser,  // is_fill[0], symbol_end[1], no_carrier[2]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import ocd_pkg::*;

    logic signed [VAL_W-1:0] fill_reg;
    map_wr_t                 map_wr;
    logic [IDX_W-1:0]        map_rd_addr;
    logic [MODE_W-1:0]       map_rd_mode;
    result_t                 out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cfg_valid)
        begin
            fill_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    ocd_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (map_wr),
        .rd_addr (map_rd_addr),
        .rd_mode (map_rd_mode)
    );

    ocd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser),
        .in_index    (s_axis_tdata[7:0]),
        .in_mode     (s_axis_tdata[11:8]),
        .in_value    (s_axis_tdata[19:12]),
        .fill_value  (fill_reg),
        .map_wr      (map_wr),
        .map_rd_addr (map_rd_addr),
        .map_rd_mode (map_rd_mode),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_res     (out_res)
    );

    assign m_axis_tdata = out_res.value;
    assign m_axis_tlast = out_res.last;
    assign m_axis_tuser = {out_res.no_carrier, out_res.symbol_end, out_res.is_fill};

endmodule

// ----- hdl/ocd_map.sv -----
// ----------------------------------------------------------------------------
// Carrier mode map
// One write and one registered read per cycle; per-entry valid bits make
// entries that were never written read as unused right after reset.
// ----------------------------------------------------------------------------
module ocd_map (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ocd_pkg::map_wr_t              wr,
    input  logic [ocd_pkg::IDX_W-1:0]     rd_addr,
    output logic [ocd_pkg::MODE_W-1:0]    rd_mode
);
    import ocd_pkg::*;

    logic [MODE_W-1:0]   mode_mem [CARRIERS];
    logic [CARRIERS-1:0] valid_reg;
    logic [MODE_W-1:0]   q_reg;
    logic                q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mode_mem[wr.addr] <= wr.mode;
        end
        q_reg <= mode_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            q_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_mode = q_valid_reg ? q_reg : '0;

endmodule

// ----- hdl/ocd_seq.sv -----
// ----------------------------------------------------------------------------
// Depuncturer sequencer
// Walks the carrier pointer through the map one carrier at a time, works out
// the fill positions of the current pattern and sends the results out.
// ----------------------------------------------------------------------------
module ocd_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_action,
    input  logic [ocd_pkg::IDX_W-1:0]         in_index,
    input  logic [ocd_pkg::MODE_W-1:0]        in_mode,
    input  logic signed [ocd_pkg::VAL_W-1:0]  in_value,
    input  logic signed [ocd_pkg::VAL_W-1:0]  fill_value,
    output ocd_pkg::map_wr_t                  map_wr,
    output logic [ocd_pkg::IDX_W-1:0]         map_rd_addr,
    input  logic [ocd_pkg::MODE_W-1:0]        map_rd_mode,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ocd_pkg::result_t                  out_res
);
    import ocd_pkg::*;

    state_t                  state_reg, state_next;
    purpose_t                pur_reg, pur_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [REP_W-1:0]        rep_reg, rep_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        nres_reg, nres_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    nc_reg, nc_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_res_reg, out_res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pur_reg       <= PUR_START;
            ptr_reg       <= PTR_W'(CARRIERS);
            rep_reg       <= '0;
            pos_reg       <= '0;
            nres_reg      <= '0;
            idx_reg       <= '0;
            nc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pur_reg       <= pur_next;
            ptr_reg       <= ptr_next;
            rep_reg       <= rep_next;
            pos_reg       <= pos_next;
            nres_reg      <= nres_next;
            idx_reg       <= idx_next;
            nc_reg        <= nc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        out_res_reg <= out_res_next;
    end

    always_comb
    begin
        logic [POS_W-1:0] len;
        logic [15:0]      pbits;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] p1;
        logic [POS_W-1:0] p2;
        logic             fill1;
        logic             fill2;
        logic [POS_W-1:0] new_pos;
        logic             wrap;
        logic [REP_W:0]   rep_inc;
        logic             done;
        logic             last_beat;

        state_next     = state_reg;
        pur_next       = pur_reg;
        ptr_next       = ptr_reg;
        rep_next       = rep_reg;
        pos_next       = pos_reg;
        nres_next      = nres_reg;
        idx_next       = idx_reg;
        nc_next        = nc_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        in_ready       = 1'b0;
        map_wr         = '0;

        len     = plen_of(map_rd_mode);
        pbits   = pbits_of(map_rd_mode);
        pos     = (pos_reg >= len) ? '0 : pos_reg;
        p1      = pos + POS_W'(1);
        p2      = pos + POS_W'(2);
        fill1   = (p1 < len) && !pbits[p1];
        fill2   = fill1 && (p2 < len) && !pbits[p2];
        new_pos = p1 + POS_W'(fill1) + POS_W'(fill2);
        wrap    = (new_pos >= len);
        rep_inc = {1'b0, rep_reg} + (REP_W+1)'(1);
        done    = wrap && (rep_inc >= rep_of(map_rd_mode));
        last_beat = (idx_reg == nres_reg - CNT_W'(1));

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_action)
                        ACT_LOAD:
                        begin
                            map_wr.en   = (in_mode <= MODE_MAX);
                            map_wr.addr = in_index;
                            map_wr.mode = in_mode;
                        end
                        ACT_START:
                        begin
                            ptr_next   = '0;
                            rep_next   = '0;
                            pos_next   = '0;
                            pur_next   = PUR_START;
                            state_next = ST_WAIT;
                        end
                        ACT_DATA:
                        begin
                            val_next   = in_value;
                            pur_next   = PUR_DATA;
                            state_next = ST_WAIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WAIT:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                idx_next = '0;
                nc_next  = 1'b0;
                if (ptr_reg[PTR_W-1])
                begin
                    if (pur_reg == PUR_START)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        nc_next    = (pur_reg == PUR_DATA);
                        if (pur_reg == PUR_DATA)
                        begin
                            nres_next = CNT_W'(1);
                        end
                        state_next = ST_EMIT;
                    end
                end
                else if (map_rd_mode == '0)
                begin
                    ptr_next   = ptr_reg + PTR_W'(1);
                    rep_next   = '0;
                    pos_next   = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    case (pur_reg)
                        PUR_START:
                        begin
                            state_next = ST_IDLE;
                        end
                        PUR_AFTER:
                        begin
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            nres_next = CNT_W'(1) + CNT_W'(fill1) + CNT_W'(fill2);
                            pos_next  = wrap ? '0 : new_pos;
                            if (done)
                            begin
                                rep_next   = '0;
                                ptr_next   = ptr_reg + PTR_W'(1);
                                pur_next   = PUR_AFTER;
                                state_next = ST_WAIT;
                            end
                            else
                            begin
                                if (wrap)
                                begin
                                    rep_next = rep_inc[REP_W-1:0];
                                end
                                state_next = ST_EMIT;
                            end
                        end
                    endcase
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_res_next.value      = nc_reg ? '0 :
                                              (idx_reg == '0) ? val_reg : fill_value;
                    out_res_next.is_fill    = !nc_reg && (idx_reg != '0);
                    out_res_next.last       = last_beat;
                    out_res_next.symbol_end = last_beat && !nc_reg && ptr_reg[PTR_W-1];
                    out_res_next.no_carrier = nc_reg;
                    if (last_beat)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign map_rd_addr = ptr_reg[IDX_W-1:0];
    assign out_valid   = out_valid_reg;
    assign out_res     = out_res_reg;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depuncturer regression bench
// Loads carrier mode maps, starts symbols and streams soft bits through the
// depuncturer under random sender gaps and receiver stalls. Each beat is
// checked against a bench model of mode map, carrier pointer, repeat counter
// and pattern position, or against a fixed beat for directed no-carrier items.
// ----------------------------------------------------------------------------
module tb;

    import ocd_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS  = 270;
    localparam int         SETTLE_CYCLES = 2 * CARRIERS + 24;
    localparam int         WATCHDOG      = 6000;

    localparam logic [35:0] REP_VEC  = {4'd4, 4'd2, 4'd3, 4'd4, 4'd2, 4'd8, 4'd1, 4'd4, 4'd2};
    localparam logic [35:0] PLEN_VEC = {4'd6, 4'd10, 4'd6, 4'd4, 4'd6, 4'd1, 4'd6, 4'd1, 4'd1};
    localparam logic [89:0] PAT_VEC  = {10'h01B, 10'h19B, 10'h01B, 10'h00B, 10'h01B,
                                        10'h001, 10'h01B, 10'h001, 10'h001};

    localparam result_t NO_CARRIER_BEAT =
        '{value: '0, is_fill: 1'b0, last: 1'b1, symbol_end: 1'b0, no_carrier: 1'b1};

    typedef struct packed {
        logic [1:0]        act;
        logic [IDX_W-1:0]  idx;
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  value;
        logic              typed;
        result_t           want;
    } soft_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    logic [MODE_W-1:0] carrier_mode [CARRIERS];
    logic [PTR_W-1:0]  cur_carrier;
    logic [REP_W:0]    reps_done;
    logic [POS_W-1:0]  pat_pos;
    logic [VAL_W-1:0]  fill_val;

    result_t    pending_beats [$];
    result_t    model_beats [$];
    result_t    got;
    int         fault_count = 0;
    int         beat_count = 0;
    int         idle_cycles = 0;
    int         stim_items = 0;
    int         burst_left = 0;
    int         max_gap = 0;
    logic [7:0] ready_mask = 8'hFF;
    int         rcv_tick = 0;

    ofdm_per_carrier_depuncturer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic soft_item_t mk(input logic [1:0] act, input logic [7:0] idx,
                                      input logic [3:0] mode, input logic [7:0] value);
        soft_item_t s;
        s       = '0;
        s.act   = act;
        s.idx   = idx;
        s.mode  = mode;
        s.value = value;
        return s;
    endfunction

    function automatic soft_item_t mk_no_carrier(input logic [7:0] value);
        soft_item_t s;
        s       = mk(ACT_DATA, 8'h00, 4'h0, value);
        s.typed = 1'b1;
        s.want  = NO_CARRIER_BEAT;
        return s;
    endfunction

    function automatic int first_used(input int from);
        for (int c = from; c < CARRIERS; c++)
        begin
            if (carrier_mode[c] != 0)
                return c;
        end
        return CARRIERS;
    endfunction

    task automatic queue_beat(input result_t b);
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic stage_beat(input result_t b);
        model_beats.insert(model_beats.size(), b);
    endtask

    task automatic depuncture(input soft_item_t s);
        int      m;
        int      len;
        int      pos;
        int      k;
        logic [9:0] pat;
        result_t beats [3];
        case (s.act)
            ACT_LOAD:
                if (s.mode <= MODE_MAX)
                    carrier_mode[s.idx] = s.mode;
            ACT_START:
            begin
                cur_carrier = PTR_W'(first_used(0));
                reps_done   = '0;
                pat_pos     = '0;
            end
            ACT_DATA:
            begin
                if (cur_carrier < CARRIERS && carrier_mode[cur_carrier[IDX_W-1:0]] == 0)
                begin
                    cur_carrier = PTR_W'(first_used(int'(cur_carrier)));
                    reps_done   = '0;
                    pat_pos     = '0;
                end
                if (cur_carrier >= CARRIERS)
                    stage_beat(NO_CARRIER_BEAT);
                else
                begin
                    m   = int'(carrier_mode[cur_carrier[IDX_W-1:0]]);
                    len = int'(PLEN_VEC[(m - 1) * 4 +: 4]);
                    pat = PAT_VEC[(m - 1) * 10 +: 10];
                    pos = (int'(pat_pos) >= len) ? 0 : int'(pat_pos);
                    beats[0]       = '0;
                    beats[0].value = s.value;
                    k   = 1;
                    pos++;
                    while (pos < len && k < 3 && !pat[pos])
                    begin
                        beats[k]         = '0;
                        beats[k].value   = fill_val;
                        beats[k].is_fill = 1'b1;
                        k++;
                        pos++;
                    end
                    if (pos >= len)
                    begin
                        pos = 0;
                        reps_done++;
                        if (reps_done >= REP_VEC[(m - 1) * 4 +: 4])
                        begin
                            reps_done   = '0;
                            cur_carrier = PTR_W'(first_used(int'(cur_carrier) + 1));
                        end
                    end
                    pat_pos = POS_W'(pos);
                    beats[k - 1].last       = 1'b1;
                    beats[k - 1].symbol_end = (cur_carrier >= CARRIERS);
                    for (int i = 0; i < k; i++)
                        stage_beat(beats[i]);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send(input soft_item_t s);
        if (max_gap > 0 && burst_left <= 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.act;
        s_axis_tdata  <= {4'b0000, s.value, s.mode, s.idx};
        do @(posedge clk); while (!s_axis_tready);
        model_beats.delete();
        depuncture(s);
        if (s.typed)
            queue_beat(s.want);
        else
            foreach (model_beats[i])
                queue_beat(model_beats[i]);
        if (s.act != ACT_UNUSED && !(s.act == ACT_LOAD && s.mode > MODE_MAX))
            stim_items++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_fill(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        fill_val = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic flag(input string what, input result_t want, input result_t seen);
        if (fault_count < 10)
        begin
            $write("%s at beat %0d: expected %0d fill %b last %b end %b none %b, ",
                   what, beat_count, $signed(want.value), want.is_fill, want.last,
                   want.symbol_end, want.no_carrier);
            $display("got %0d fill %b last %b end %b none %b",
                     $signed(seen.value), seen.is_fill, seen.last, seen.symbol_end,
                     seen.no_carrier);
        end
        fault_count++;
    endtask

    always @(negedge clk)
    begin
        m_axis_tready <= ready_mask[rcv_tick % 8];
        rcv_tick      <= rcv_tick + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{value: m_axis_tdata, is_fill: m_axis_tuser[0], last: m_axis_tlast,
                    symbol_end: m_axis_tuser[1], no_carrier: m_axis_tuser[2]};
            if (pending_beats.size() == 0)
                flag("Unexpected beat", '0, got);
            else if (got !== pending_beats[0])
                flag("Beat mismatch", pending_beats.pop_front(), got);
            else
                void'(pending_beats.pop_front());
            beat_count++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("ofdm_per_carrier_depuncturer_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        soft_item_t directed [$];
        int phase;
        int used;
        int guard;
        int pick;

        foreach (carrier_mode[c])
            carrier_mode[c] = '0;
        cur_carrier = PTR_W'(CARRIERS);
        reps_done   = '0;
        pat_pos     = '0;
        fill_val    = '0;

        directed = '{
            mk_no_carrier(8'h00),
            mk(ACT_START, 8'h00, 4'h0, 8'h00),
            mk_no_carrier(8'h7F),
            mk(ACT_LOAD, 8'd0, 4'd3, 8'h00),
            mk(ACT_LOAD, 8'd255, 4'd8, 8'h00),
            mk(ACT_LOAD, 8'd7, 4'd10, 8'h00),
            mk(ACT_LOAD, 8'd0, 4'd15, 8'hFF),
            mk(ACT_UNUSED, 8'hFF, 4'hF, 8'hFF),
            mk(ACT_START, 8'h00, 4'h0, 8'h00),
            mk(ACT_DATA, 8'h00, 4'h0, 8'h7F),
            mk(ACT_DATA, 8'h00, 4'h0, 8'h80),
            mk(ACT_DATA, 8'h00, 4'h0, 8'h55),
            mk(ACT_DATA, 8'h00, 4'h0, 8'hAA),
            mk(ACT_DATA, 8'h00, 4'h0, 8'h01),
            mk(ACT_DATA, 8'h00, 4'h0, 8'h02),
            mk(ACT_DATA, 8'h00, 4'h0, 8'h03),
            mk(ACT_DATA, 8'h00, 4'h0, 8'h04),
            mk(ACT_LOAD, 8'd255, 4'd6, 8'h00),
            mk(ACT_DATA, 8'h00, 4'h0, 8'h05),
            mk(ACT_LOAD, 8'd255, 4'd0, 8'h00),
            mk_no_carrier(8'h06),
            mk(ACT_LOAD, 8'd1, 4'd1, 8'h00),
            mk(ACT_LOAD, 8'd254, 4'd9, 8'h00),
            mk(ACT_START, 8'h00, 4'h0, 8'h00),
            mk(ACT_DATA, 8'hFF, 4'hF, 8'hFF)
        };

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_fill(8'h80);
        max_gap    = 3;
        ready_mask = 8'b1011_0111;
        foreach (directed[i])
            send(directed[i]);

        stim_items = 0;
        phase      = 0;
        while (stim_items < RANDOM_ITEMS)
        begin
            settle();
            case (phase)
                0:       write_fill(8'h7F);
                1:       write_fill(8'h00);
                default: write_fill(8'($urandom));
            endcase
            if (phase % 4 == 3)
            begin
                max_gap    = 0;
                ready_mask = 8'hFF;
            end
            else
            begin
                max_gap    = $urandom_range(1, 6);
                ready_mask = 8'($urandom_range(1, 255));
            end

            for (int c = 0; c < CARRIERS; c++)
                if (carrier_mode[c] != 0)
                    send(mk(ACT_LOAD, 8'(c), 4'h0, 8'($urandom)));
            used = $urandom_range(1, 4);
            for (int n = 0; n < used; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send(mk(ACT_LOAD, 8'($urandom), 4'($urandom_range(10, 15)), 8'($urandom)));
                send(mk(ACT_LOAD, 8'($urandom), 4'($urandom_range(1, 9)), 8'($urandom)));
            end
            send(mk(ACT_START, 8'($urandom), 4'($urandom), 8'($urandom)));

            guard = 0;
            while (cur_carrier < CARRIERS && guard < 48)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send(mk(ACT_UNUSED, 8'($urandom), 4'($urandom), 8'($urandom)));
                else if (pick < 8)
                    send(mk(ACT_LOAD,
                            $urandom_range(0, 1) ? cur_carrier[IDX_W-1:0] : 8'($urandom),
                            4'($urandom), 8'($urandom)));
                else if (pick < 10)
                    send(mk(ACT_START, 8'($urandom), 4'($urandom), 8'($urandom)));
                else
                    send(mk(ACT_DATA, 8'($urandom), 4'($urandom), 8'($urandom)));
                guard++;
            end
            repeat ($urandom_range(0, 2))
                send(mk(ACT_DATA, 8'($urandom), 4'($urandom), 8'($urandom)));
            phase++;
        end

        settle();
        if (fault_count == 0)
            $display("ofdm_per_carrier_depuncturer_top regression: pass");
        else
            $display("ofdm_per_carrier_depuncturer_top regression: fail");
        $finish;
    end

endmodule
